@@ src/kma_pkg.sv @@
// ----------------------------------------------------------------------------
// kma_pkg
// Shared constants, codes and types of the k-means assignment block.
// ----------------------------------------------------------------------------
`default_nettype none

package kma_pkg;

    // Sizing
    localparam int MAX_MEANS  = 16;
    localparam int COORD_BITS = 16;
    localparam int IDX_W      = $clog2(MAX_MEANS);

    // Fixed field widths
    localparam int OP_W   = 2;
    localparam int MIDX_W = 4;
    localparam int CFG_W  = 5;
    localparam int SUM_W  = 40;
    localparam int CNT_W  = 20;

    // Squared distance: |d|^2 fits 2C+1 bits, the sum of two one more
    localparam int SQ_W   = 2 * COORD_BITS + 1;
    localparam int DIST_W = SQ_W + 1;

    // Operation codes
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_POINT = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // Result kinds
    localparam logic RK_NEAREST = 1'b0;
    localparam logic RK_ACCUM   = 1'b1;

    // Saturation limits
    localparam logic [SUM_W-1:0] SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_EMIT
    } kma_state_t;

    // Search token handed from cell to cell
    typedef struct packed {
        logic                         valid;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic                         has_best;
        logic [DIST_W-1:0]            best_sq;
        logic [IDX_W-1:0]             idx;
    } kma_tok_t;

    // Broadcast command to the cell row
    typedef struct packed {
        logic                         load;
        logic                         upd;
        logic [IDX_W-1:0]             slot;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } kma_cmd_t;

    // Accumulator contents of one cell
    typedef struct packed {
        logic signed [SUM_W-1:0] sum_x;
        logic signed [SUM_W-1:0] sum_y;
        logic [CNT_W-1:0]        count;
    } kma_acc_t;

    // One result item
    typedef struct packed {
        logic                    kind;
        logic [MIDX_W-1:0]       idx;
        logic signed [SUM_W-1:0] sum_x;
        logic signed [SUM_W-1:0] sum_y;
        logic [CNT_W-1:0]        count;
    } kma_res_t;

endpackage

`default_nettype wire

@@ src/kma_item_if.sv @@
// ----------------------------------------------------------------------------
// kma_item_if
// Input item channel: operation, slot and coordinates with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface kma_item_if;
    import kma_pkg::*;

    logic                         valid;
    logic                         ready;
    logic [OP_W-1:0]              operation;
    logic [MIDX_W-1:0]            mean_slot;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;

    modport source (output valid, operation, mean_slot, coord_x, coord_y, input ready);
    modport sink   (input valid, operation, mean_slot, coord_x, coord_y, output ready);
endinterface

`default_nettype wire

@@ src/kma_result_if.sv @@
// ----------------------------------------------------------------------------
// kma_result_if
// Result channel: nearest index or accumulator readout with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface kma_result_if;
    import kma_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    result_kind;
    logic [MIDX_W-1:0]       nearest_index;
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic [CNT_W-1:0]        point_count;

    modport source (output valid, result_kind, nearest_index, sum_x, sum_y, point_count,
                    input ready);
    modport sink   (input valid, result_kind, nearest_index, sum_x, sum_y, point_count,
                    output ready);
endinterface

`default_nettype wire

@@ src/kma_cfg_if.sv @@
// ----------------------------------------------------------------------------
// kma_cfg_if
// Configuration write channel carrying the number of means in use.
// ----------------------------------------------------------------------------
`default_nettype none

interface kma_cfg_if;
    import kma_pkg::*;

    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

@@ src/kmeans_assign_accumulate.sv @@
// ----------------------------------------------------------------------------
// kmeans_assign_accumulate
// One k-means assignment pass over 2-D Q8.8 points held in a row of cells.
//
// Channels: items (operation, mean_slot, coord_x, coord_y), results
// (result_kind, nearest_index, sum_x, sum_y, point_count) and cfg, which
// writes num_means; cfg is always ready. All are valid/ready transactions.
// A load transaction writes a mean, clears its sums and count, and
// returns nothing; the next item is taken in the following cycle.
// A point transaction sends a search token through the stage A and B
// registers of each cell in turn; the cell at k-1, k the number of means
// in use, ends the walk. A point's or read's result is registered in
// pend_reg, then loaded into the output register once that is free.
// One item is worked at a time: loads leave the block idle, while points
// and reads hold off new items until their result has been loaded.
// Reset clears all sums and counts and sets num_means to 1; mean
// coordinates hold no value until loaded.
// A finished result waits in the output register while the receiver stalls;
// the next item may be accepted meanwhile, and a further result waits in
// the block until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module kmeans_assign_accumulate (
    input  logic         clk,
    input  logic         rst_n,
    kma_cfg_if.sink      cfg,
    kma_item_if.sink     items,
    kma_result_if.source results
);
    import kma_pkg::*;

    kma_state_t       state_reg, state_next;
    logic [CFG_W-1:0] num_means_reg;
    kma_res_t         pend_reg, pend_next;
    kma_res_t         out_reg;
    logic             out_valid_reg, out_valid_next;
    logic             out_load;

    kma_cmd_t         cmd;
    kma_tok_t         tok_in;
    kma_tok_t         tok_out [MAX_MEANS];
    kma_acc_t         acc     [MAX_MEANS];
    kma_tok_t         done_tok;

    logic             accept;
    logic             slot_ok;
    logic [IDX_W-1:0] slot_idx;
    logic [31:0]      k_eff;
    logic [IDX_W-1:0] last_idx;

    // Configuration register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_means_reg <= CFG_W'(1);
        end
        else if (cfg.valid)
        begin
            num_means_reg <= cfg.data;
        end
    end

    // Means in use, clamped to 1..MAX_MEANS
    always_comb
    begin
        if (num_means_reg == '0)
            k_eff = 32'd1;
        else if (32'(num_means_reg) > 32'(MAX_MEANS))
            k_eff = 32'(MAX_MEANS);
        else
            k_eff = 32'(num_means_reg);
        last_idx = IDX_W'(k_eff - 32'd1);
    end

    assign accept   = items.valid && items.ready;
    assign slot_ok  = 32'(items.mean_slot) < 32'(MAX_MEANS);
    assign slot_idx = IDX_W'(items.mean_slot);
    assign done_tok = tok_out[last_idx];

    // Row of mean cells
    kma_chain u_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .tok_in  (tok_in),
        .tok_out (tok_out),
        .acc     (acc)
    );

    // Controller: next state, cell command and pending result
    always_comb
    begin
        state_next  = state_reg;
        pend_next   = pend_reg;
        out_load    = 1'b0;
        items.ready = 1'b0;

        cmd.load = 1'b0;
        cmd.upd  = 1'b0;
        cmd.slot = slot_idx;
        cmd.x    = items.coord_x;
        cmd.y    = items.coord_y;

        tok_in          = '0;
        tok_in.x        = items.coord_x;
        tok_in.y        = items.coord_y;

        unique case (state_reg)
            S_IDLE:
            begin
                items.ready = 1'b1;
                if (items.valid)
                begin
                    case (items.operation)
                        OP_LOAD:
                        begin
                            cmd.load = slot_ok;
                        end
                        OP_POINT:
                        begin
                            tok_in.valid = 1'b1;
                            state_next   = S_SEARCH;
                        end
                        OP_READ:
                        begin
                            pend_next.kind = RK_ACCUM;
                            pend_next.idx  = '0;
                            if (slot_ok)
                            begin
                                pend_next.sum_x = acc[slot_idx].sum_x;
                                pend_next.sum_y = acc[slot_idx].sum_y;
                                pend_next.count = acc[slot_idx].count;
                            end
                            else
                            begin
                                pend_next.sum_x = '0;
                                pend_next.sum_y = '0;
                                pend_next.count = '0;
                            end
                            state_next = S_EMIT;
                        end
                        default:
                        begin
                            // unused operation code: ignored
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                if (done_tok.valid)
                begin
                    cmd.upd         = 1'b1;
                    cmd.slot        = done_tok.idx;
                    cmd.x           = done_tok.x;
                    cmd.y           = done_tok.y;
                    pend_next.kind  = RK_NEAREST;
                    pend_next.idx   = MIDX_W'(done_tok.idx);
                    pend_next.sum_x = '0;
                    pend_next.sum_y = '0;
                    pend_next.count = '0;
                    state_next      = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (results.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= pend_reg;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.result_kind   = out_reg.kind;
    assign results.nearest_index = out_reg.idx;
    assign results.sum_x         = out_reg.sum_x;
    assign results.sum_y         = out_reg.sum_y;
    assign results.point_count   = out_reg.count;

    // Checks
    a_nearest_zero_sums: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && (results.result_kind == RK_NEAREST) |->
            (results.sum_x == '0) && (results.sum_y == '0) && (results.point_count == '0))
        else $error("nearest-mean result carries non-zero sums");

    a_readout_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && (results.result_kind == RK_ACCUM) |-> (results.nearest_index == '0))
        else $error("readout carries a non-zero index");

    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.upd |-> !cmd.load)
        else $error("load and update issued in the same cycle");

    a_point_starts_search: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (items.operation == OP_POINT) |=> (state_reg == S_SEARCH))
        else $error("point transaction did not start a search");

    a_emit_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) && out_valid_reg && !results.ready |=> (state_reg == S_EMIT))
        else $error("pending result dropped while output stalled");

endmodule

`default_nettype wire

@@ src/kma_cell.sv @@
// ----------------------------------------------------------------------------
// kma_cell
// One mean of the row: holds its coordinates and accumulators, scores a
// passing search token over two register stages and hands it on.
// ----------------------------------------------------------------------------
`default_nettype none

module kma_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [kma_pkg::IDX_W-1:0] cell_id,
    input  logic              sel,
    input  kma_pkg::kma_cmd_t cmd,
    input  kma_pkg::kma_tok_t tok_in,
    output kma_pkg::kma_tok_t tok_out,
    output kma_pkg::kma_acc_t acc
);
    import kma_pkg::*;

    logic signed [COORD_BITS-1:0] mean_x_reg;
    logic signed [COORD_BITS-1:0] mean_y_reg;
    kma_acc_t                     acc_reg, acc_next;

    kma_tok_t                     a_tok_reg;
    logic [SQ_W-1:0]              a_sqx_reg, a_sqy_reg;
    kma_tok_t                     b_tok_reg, b_tok_next;

    logic signed [COORD_BITS:0]     dx, dy;
    logic signed [2*COORD_BITS+1:0] px, py;
    logic [DIST_W-1:0]              sq_sum;
    logic                           take;
    logic signed [SUM_W:0]          sx, sy;

    // Mean coordinates, written by a load to this slot
    always_ff @(posedge clk)
    begin
        if (cmd.load && sel)
        begin
            mean_x_reg <= cmd.x;
            mean_y_reg <= cmd.y;
        end
    end

    // Stage A: coordinate differences squared
    always_comb
    begin
        dx = {mean_x_reg[COORD_BITS-1], mean_x_reg} - {tok_in.x[COORD_BITS-1], tok_in.x};
        dy = {mean_y_reg[COORD_BITS-1], mean_y_reg} - {tok_in.y[COORD_BITS-1], tok_in.y};
        px = dx * dx;
        py = dy * dy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_tok_reg <= '0;
        end
        else
        begin
            a_tok_reg <= tok_in;
        end
    end

    always_ff @(posedge clk)
    begin
        a_sqx_reg <= px[SQ_W-1:0];
        a_sqy_reg <= py[SQ_W-1:0];
    end

    // Stage B: distance compare, strict less-than keeps the earlier mean on ties
    always_comb
    begin
        sq_sum     = {1'b0, a_sqx_reg} + {1'b0, a_sqy_reg};
        take       = !a_tok_reg.has_best || (sq_sum < a_tok_reg.best_sq);
        b_tok_next = a_tok_reg;
        b_tok_next.has_best = 1'b1;
        if (take)
        begin
            b_tok_next.best_sq = sq_sum;
            b_tok_next.idx     = cell_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_tok_reg <= '0;
        end
        else
        begin
            b_tok_reg <= b_tok_next;
        end
    end

    assign tok_out = b_tok_reg;

    // Saturating accumulation, cleared by a load
    always_comb
    begin
        sx = {acc_reg.sum_x[SUM_W-1], acc_reg.sum_x}
           + {{(SUM_W+1-COORD_BITS){cmd.x[COORD_BITS-1]}}, cmd.x};
        sy = {acc_reg.sum_y[SUM_W-1], acc_reg.sum_y}
           + {{(SUM_W+1-COORD_BITS){cmd.y[COORD_BITS-1]}}, cmd.y};
        acc_next = acc_reg;
        if (cmd.load && sel)
        begin
            acc_next = '0;
        end
        else if (cmd.upd && sel)
        begin
            if (sx[SUM_W] != sx[SUM_W-1])
                acc_next.sum_x = sx[SUM_W] ? SUM_MIN : SUM_MAX;
            else
                acc_next.sum_x = sx[SUM_W-1:0];
            if (sy[SUM_W] != sy[SUM_W-1])
                acc_next.sum_y = sy[SUM_W] ? SUM_MIN : SUM_MAX;
            else
                acc_next.sum_y = sy[SUM_W-1:0];
            if (acc_reg.count != COUNT_MAX)
                acc_next.count = acc_reg.count + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

@@ src/kma_chain.sv @@
// ----------------------------------------------------------------------------
// kma_chain
// Row of mean cells: the search token walks from cell 0 upwards, and the
// broadcast command is decoded into a per-cell select.
// ----------------------------------------------------------------------------
`default_nettype none

module kma_chain (
    input  logic              clk,
    input  logic              rst_n,
    input  kma_pkg::kma_cmd_t cmd,
    input  kma_pkg::kma_tok_t tok_in,
    output kma_pkg::kma_tok_t tok_out [kma_pkg::MAX_MEANS],
    output kma_pkg::kma_acc_t acc     [kma_pkg::MAX_MEANS]
);
    import kma_pkg::*;

    kma_tok_t link [MAX_MEANS+1];

    assign link[0] = tok_in;

    // One cell per mean slot
    for (genvar i = 0; i < MAX_MEANS; i++)
    begin : g_cell
        logic sel;

        assign sel = (cmd.slot == IDX_W'(i));

        kma_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cell_id (IDX_W'(i)),
            .sel     (sel),
            .cmd     (cmd),
            .tok_in  (link[i]),
            .tok_out (link[i+1]),
            .acc     (acc[i])
        );

        assign tok_out[i] = link[i+1];
    end

endmodule

`default_nettype wire
